// ===== rtl/core/mdsr_pkg.sv =====
// Shared types and constants for the multichannel DAC slew ramp unit.
`default_nettype none

package mdsr_pkg;

   localparam int NUM_CHANNELS = 8;
   localparam int CH_W         = $clog2(NUM_CHANNELS);
   localparam int LEVEL_W      = 9;
   localparam int CODE_W       = 12;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEVEL_W-1:0] LEVEL_MAX    = 9'd500;
   localparam logic [CODE_W-1:0]  CODE_MAX     = 12'd4095;
   localparam logic [5:0]         CMD_BASE     = 6'h30;
   localparam logic [7:0]         INVERT_RESET = 8'h0F;

   // Step divide by 20: (diff >> 2) * 205 >> 10 is exact for diff <= 500
   localparam logic [7:0]  STEP_RECIP    = 8'd205;
   // Code divide by 500: y * 16777 >> 23 is the quotient or one below it
   localparam logic [14:0] CODE_RECIP    = 15'd16777;
   localparam int          CODE_SHIFT    = 23;
   localparam int          PROD_W        = 36;
   localparam int          SCALED_W      = 21;

   typedef enum logic {
      KIND_SET  = 1'b0,
      KIND_TICK = 1'b1
   } kind_type;

   typedef struct packed {
      logic [0:0]         kind;
      logic [2:0]         channel_sel;
      logic [LEVEL_W-1:0] target_value;
   } req_type;

   typedef struct packed {
      logic [2:0]         out_channel;
      logic [LEVEL_W-1:0] level;
      logic [5:0]         command_byte;
      logic [7:0]         data_high;
      logic [7:0]         data_low;
      logic               last;
   } rsp_type;

   // Classified transaction passed from front to back
   typedef struct packed {
      logic               is_tick;
      logic               chan_ok;
      logic [CH_W-1:0]    chan;
      logic [LEVEL_W-1:0] target;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WALK,
      BK_STEP,
      BK_DIV,
      BK_EMIT
   } back_state_type;

endpackage

`default_nettype wire

// ===== rtl/core/mdsr_front.sv =====
// Front end: accepts request transactions, classifies them and saturates targets.
`default_nettype none

module mdsr_front
   import mdsr_pkg::*;
(
   input  wire logic    start,
   input  wire logic    queue_full,
   input  wire req_type req_payload,
   output logic         push,
   output cmd_type      push_cmd
);

   always_comb begin
      push                = start && !queue_full;
      push_cmd.is_tick    = (req_payload.kind == KIND_TICK);
      push_cmd.chan_ok    = ({1'b0, req_payload.channel_sel} < 4'(NUM_CHANNELS));
      push_cmd.chan       = CH_W'(req_payload.channel_sel);
      push_cmd.target     = (req_payload.target_value > LEVEL_MAX) ?
                            LEVEL_MAX : req_payload.target_value;
   end

endmodule

`default_nettype wire

// ===== rtl/core/mdsr_queue.sv =====
// Short command queue between front and back.
`default_nettype none

module mdsr_queue
   import mdsr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire cmd_type push_cmd,
   input  wire logic    pop,
   output logic         full,
   output logic         not_empty,
   output cmd_type      head
);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   always_comb begin
      full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
      not_empty = (count_ff != '0);
      head      = entry_ff[rd_ptr_ff];
      do_push   = push && !full;
      do_pop    = pop && not_empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mdsr_back.sv =====
// Back end: channel level store, ramp sequencer, code scaling and frame output.
`default_nettype none

module mdsr_back
   import mdsr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata,
   input  wire logic       cmd_valid,
   input  wire cmd_type    cmd,
   output logic            cmd_pop,
   output logic            rsp_strobe,
   output rsp_type         rsp_payload
);

   back_state_type       state_ff, state_in;
   logic [LEVEL_W-1:0]   target_ff [NUM_CHANNELS];
   logic [LEVEL_W-1:0]   current_ff [NUM_CHANNELS];
   logic [7:0]           invert_ff;
   logic [NUM_CHANNELS-1:0] mask_ff, mask_in;
   logic [CH_W-1:0]      idx_ff, idx_in;
   logic [LEVEL_W-1:0]   level_ff;
   logic [SCALED_W-1:0]  scaled_ff;
   logic [PROD_W-1:0]    prod_ff;
   logic                 strobe_ff;
   rsp_type              rsp_ff;

   logic [LEVEL_W-1:0]   cur, tgt, diff, step, next_level;
   logic [14:0]          step_prod;
   logic [CODE_W-1:0]    quot;
   logic [SCALED_W-1:0]  quot_x500, remainder;
   logic [CODE_W-1:0]    code, code_out;
   logic                 invert_bit, is_last;
   logic                 wr_target, wr_current;
   rsp_type              frame;

   // Ramp step for the channel under the walk pointer
   always_comb begin
      cur        = current_ff[idx_ff];
      tgt        = target_ff[idx_ff];
      diff       = (tgt > cur) ? (tgt - cur) : (cur - tgt);
      step_prod  = 15'(diff >> 2) * 15'(STEP_RECIP);
      step       = LEVEL_W'(step_prod >> 10);
      if (step == '0) begin
         step = LEVEL_W'(1);
      end
      next_level = (tgt > cur) ? (cur + step) : (cur - step);
   end

   // Finish the divide by 500 with one correction, then apply inversion
   always_comb begin
      quot       = prod_ff[CODE_SHIFT +: CODE_W];
      quot_x500  = (SCALED_W'(quot) << 9) - (SCALED_W'(quot) << 3) - (SCALED_W'(quot) << 2);
      remainder  = scaled_ff - quot_x500;
      code       = (remainder >= SCALED_W'(LEVEL_MAX)) ? quot + 1'b1 : quot;
      invert_bit = ({1'b0, idx_ff} < (CH_W + 1)'(8)) && invert_ff[3'(idx_ff)];
      code_out   = invert_bit ? (CODE_MAX - code) : code;
      is_last    = ((mask_ff >> idx_ff) >> 1) == '0;

      frame.out_channel  = 3'(idx_ff);
      frame.level        = level_ff;
      frame.command_byte = CMD_BASE | 6'(idx_ff);
      frame.data_high    = code_out[11:4];
      frame.data_low     = {code_out[3:0], 4'h0};
      frame.last         = is_last;
   end

   always_comb begin
      state_in   = state_ff;
      mask_in    = mask_ff;
      idx_in     = idx_ff;
      cmd_pop    = 1'b0;
      wr_target  = 1'b0;
      wr_current = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.is_tick) begin
                  for (int c = 0; c < NUM_CHANNELS; c++) begin
                     mask_in[c] = (current_ff[c] != target_ff[c]);
                  end
                  idx_in   = '0;
                  state_in = BK_WALK;
               end else begin
                  wr_target = cmd.chan_ok;
               end
            end
         end
         BK_WALK: begin
            if (mask_ff[idx_ff]) begin
               state_in = BK_STEP;
            end else if (idx_ff == CH_W'(NUM_CHANNELS - 1)) begin
               state_in = BK_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         BK_STEP: begin
            wr_current = 1'b1;
            state_in   = BK_DIV;
         end
         BK_DIV: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (idx_ff == CH_W'(NUM_CHANNELS - 1)) begin
               state_in = BK_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = BK_WALK;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BK_IDLE;
         invert_ff <= INVERT_RESET;
         strobe_ff <= 1'b0;
         mask_ff   <= '0;
         idx_ff    <= '0;
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            target_ff[c]  <= '0;
            current_ff[c] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         mask_ff   <= mask_in;
         idx_ff    <= idx_in;
         strobe_ff <= (state_ff == BK_EMIT);
         if (csr_we) begin
            invert_ff <= csr_wdata;
         end
         if (wr_target) begin
            target_ff[cmd.chan] <= cmd.target;
         end
         if (wr_current) begin
            current_ff[idx_ff] <= next_level;
         end
      end
   end

   // Datapath registers: scale by 4095, multiply by reciprocal, hold the frame
   always_ff @(posedge clock) begin
      if (state_ff == BK_STEP) begin
         level_ff  <= next_level;
         scaled_ff <= (SCALED_W'(next_level) << 12) - SCALED_W'(next_level);
      end
      if (state_ff == BK_DIV) begin
         prod_ff <= PROD_W'(scaled_ff) * PROD_W'(CODE_RECIP);
      end
      if (state_ff == BK_EMIT) begin
         rsp_ff <= frame;
      end
   end

   assign rsp_strobe  = strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire

// ===== rtl/core/multichannel_dac_slew_ramp_unit.sv =====
// A set transaction is written to the target store once it leaves the queue while the back end
// is idle. For a tick, the back end visits every channel in turn; an unchanged channel only gets
// a visit, an updated one goes through visit, step and scale, reciprocal multiply, and correct
// and register, and its frame is then registered onto the outputs. A two-entry queue lets start
// be taken while a tick runs.
// Frames leave on a one-cycle strobe; the receiver cannot stall. Synchronous reset clears
// all levels and targets and loads the inversion mask with 0x0F.
`default_nettype none

module multichannel_dac_slew_ramp_unit
   import mdsr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire req_type    req_payload,
   output logic            rsp_strobe,
   output rsp_type         rsp_payload,
   input  wire logic       csr_we,
   input  wire logic [7:0] csr_wdata
);

   logic    push, queue_full, queue_not_empty, pop;
   cmd_type push_cmd, head_cmd;

   mdsr_front u_front (
      .start       (start),
      .queue_full  (queue_full),
      .req_payload (req_payload),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   mdsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .full      (queue_full),
      .not_empty (queue_not_empty),
      .head      (head_cmd)
   );

   mdsr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .cmd_valid   (queue_not_empty),
      .cmd         (head_cmd),
      .cmd_pop     (pop),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

   assign busy = queue_full;

endmodule

`default_nettype wire
